/* rtl/isei_pkg.sv */
// Shared types and fixed widths for the imperfect sensor expected impact block.
package isei_pkg;

    localparam int IMPACT_W = 32;
    localparam int TIME_W   = 32;
    localparam int TOTAL_W  = 63;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EVAL = 7'b0000010,
        S_MISS = 7'b0000100,
        S_PD   = 7'b0001000,
        S_CON  = 7'b0010000,
        S_UND  = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

endpackage

/* rtl/isei_mul.sv */
// Shared multiplier with optional half-up rounding to the probability scale.
module isei_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic [isei_pkg::IMPACT_W-1:0]          i_a,
    input  logic [FRAC_BITS:0]                     i_b,
    input  logic                                   i_rnd,
    output logic [isei_pkg::IMPACT_W+FRAC_BITS-1:0] o_prod
);
    import isei_pkg::*;

    localparam int PW     = IMPACT_W + FRAC_BITS;
    localparam int FULL_W = IMPACT_W + FRAC_BITS + 1;

    logic [FULL_W-1:0] full;
    logic [FULL_W-1:0] shr;
    logic [FULL_W-1:0] half;
    logic [PW-1:0]     r_prod;

    assign half = i_rnd ? (FULL_W'(1) << (FRAC_BITS - 1)) : '0;
    assign full = (FULL_W'(i_a) * FULL_W'(i_b)) + half;
    assign shr  = full >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_rnd) begin
            r_prod <= shr[PW-1:0];
        end else begin
            r_prod <= full[PW-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule

/* rtl/imperfect_sensor_expected_impact_core.sv */
// Top level: sequencer and scenario state for the expected impact of imperfect sensors.
//
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid / o_in_stall | func, arrival_time, impact, detect_prob,
//          |           |                        | first_scenario
//  out     | output    | o_out_valid / i_out_stall | scenario_impact, total_impact
//
// States per transaction, set by the one shared multiplier: joining the open group EVAL,
// MISS; opening one with none open EVAL; closing one EVAL, PD, CON; an end transaction
// EVAL, UND, EMIT, with PD, CON before UND if it closes a group; EMIT waits on a free output.
// Synchronous active-low reset clears all scenario state and the running total.
// The output register holds a result under stall; input is taken only in the idle state.
module imperfect_sensor_expected_impact_core #(
    parameter int PROB_FRAC_BITS = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_in_valid,
    output logic                                          o_in_stall,
    input  logic                                          i_func,
    input  logic [isei_pkg::TIME_W-1:0]                   i_arrival_time,
    input  logic [isei_pkg::IMPACT_W-1:0]                 i_impact,
    input  logic [PROB_FRAC_BITS:0]                       i_detect_prob,
    input  logic                                          i_first_scenario,
    output logic                                          o_out_valid,
    input  logic                                          i_out_stall,
    output logic [isei_pkg::IMPACT_W+PROB_FRAC_BITS-1:0]  o_scenario_impact,
    output logic [isei_pkg::TOTAL_W-1:0]                  o_total_impact
);
    import isei_pkg::*;

    localparam int F     = PROB_FRAC_BITS;
    localparam int PW    = F + 1;
    localparam int ACC_W = IMPACT_W + F;
    localparam logic [PW-1:0] ONE = PW'(1) << F;

    t_state r_state, n_state;

    logic              r_func;
    logic [TIME_W-1:0] r_t;
    logic [IMPACT_W-1:0] r_imp;
    logic [PW-1:0]     r_p;
    logic              r_first;

    logic [PW-1:0]       r_rem;
    logic [ACC_W-1:0]    r_acc;
    logic [TIME_W-1:0]   r_group_time;
    logic [IMPACT_W-1:0] r_group_impact;
    logic [PW-1:0]       r_group_miss;
    logic                r_group_open;
    logic [TOTAL_W-1:0]  r_total;

    logic                r_out_valid;
    logic [ACC_W-1:0]    r_out_scn;
    logic [TOTAL_W-1:0]  r_out_tot;

    logic [IMPACT_W-1:0] mul_a;
    logic [PW-1:0]       mul_b;
    logic                mul_rnd;
    logic [ACC_W-1:0]    prod;

    logic                in_accept;
    logic                out_free;
    logic                same_group;
    logic [PW-1:0]       p_clamp;
    logic [ACC_W:0]      acc_sum;
    logic [ACC_W-1:0]    acc_sat;
    logic [TOTAL_W-1:0]  tot_base;
    logic [TOTAL_W:0]    tot_sum;
    logic [TOTAL_W-1:0]  tot_sat;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign same_group = !r_func && r_group_open && (r_t == r_group_time);
    assign p_clamp    = (i_detect_prob[F] && (|i_detect_prob[F-1:0])) ? ONE : i_detect_prob;

    assign acc_sum  = {1'b0, r_acc} + {1'b0, prod};
    assign acc_sat  = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
    assign tot_base = r_first ? '0 : r_total;
    assign tot_sum  = {1'b0, tot_base} + (TOTAL_W + 1)'(r_acc);
    assign tot_sat  = tot_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : tot_sum[TOTAL_W-1:0];

    always_comb begin
        mul_a   = IMPACT_W'(r_rem);
        mul_b   = ONE - r_group_miss;
        mul_rnd = 1'b1;
        unique case (r_state)
            S_EVAL: begin
                if (same_group) begin
                    mul_a = IMPACT_W'(r_group_miss);
                    mul_b = ONE - r_p;
                end else if (!r_group_open) begin
                    mul_a   = r_imp;
                    mul_b   = r_rem;
                    mul_rnd = 1'b0;
                end
            end
            S_PD: begin
                mul_a   = r_group_impact;
                mul_b   = prod[PW-1:0];
                mul_rnd = 1'b0;
            end
            S_CON: begin
                mul_a   = r_imp;
                mul_b   = r_rem;
                mul_rnd = 1'b0;
            end
            default: begin
                mul_a   = IMPACT_W'(r_rem);
                mul_b   = ONE - r_group_miss;
                mul_rnd = 1'b1;
            end
        endcase
    end

    isei_mul #(
        .FRAC_BITS(F)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .i_rnd  (mul_rnd),
        .o_prod (prod)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_accept) n_state = S_EVAL;
            S_EVAL: begin
                if (same_group) begin
                    n_state = S_MISS;
                end else if (r_group_open) begin
                    n_state = S_PD;
                end else if (!r_func) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_UND;
                end
            end
            S_MISS: n_state = S_IDLE;
            S_PD:   n_state = S_CON;
            S_CON:  n_state = r_func ? S_UND : S_IDLE;
            S_UND:  n_state = S_EMIT;
            S_EMIT: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func  <= i_func;
            r_t     <= i_arrival_time;
            r_imp   <= i_impact;
            r_p     <= p_clamp;
            r_first <= i_first_scenario;
        end
        if (r_state == S_EMIT && out_free) begin
            r_out_scn <= r_acc;
            r_out_tot <= tot_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_rem          <= ONE;
            r_acc          <= '0;
            r_group_time   <= '0;
            r_group_impact <= '0;
            r_group_miss   <= ONE;
            r_group_open   <= 1'b0;
            r_total        <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_EVAL: begin
                    if (!same_group && !r_group_open && !r_func) begin
                        r_group_time   <= r_t;
                        r_group_impact <= r_imp;
                        r_group_miss   <= ONE - r_p;
                        r_group_open   <= 1'b1;
                    end
                end
                S_MISS: r_group_miss <= prod[PW-1:0];
                S_PD:   r_rem <= r_rem - prod[PW-1:0];
                S_CON: begin
                    r_acc <= acc_sat;
                    if (r_func) begin
                        r_group_open <= 1'b0;
                        r_group_miss <= ONE;
                    end else begin
                        r_group_time   <= r_t;
                        r_group_impact <= r_imp;
                        r_group_miss   <= ONE - r_p;
                        r_group_open   <= 1'b1;
                    end
                end
                S_UND: r_acc <= acc_sat;
                S_EMIT: begin
                    if (out_free) begin
                        r_total        <= tot_sat;
                        r_rem          <= ONE;
                        r_acc          <= '0;
                        r_group_time   <= '0;
                        r_group_impact <= '0;
                        r_group_miss   <= ONE;
                        r_group_open   <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_scenario_impact = r_out_scn;
    assign o_total_impact    = r_out_tot;

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= ONE)
        else $error("remaining probability above one");

    a_closed_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_group_open |-> r_group_miss == ONE)
        else $error("closed group holds a miss product");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == S_EVAL)
        else $error("accepted transaction not evaluated");

    a_emit_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free) |=> (o_out_valid && r_state == S_IDLE
            && r_acc == '0 && !r_group_open))
        else $error("scenario result not loaded or state not cleared");

endmodule
